@@ src/ip_range_lookup_top_defines.svh @@
// Assertion macros used by the range lookup sequencer RTL file.
`ifndef IP_RANGE_LOOKUP_TOP_DEFINES_SVH
`define IP_RANGE_LOOKUP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that an antecedent implies a consequent on every clock edge out of reset.
`define IRL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that an antecedent implies a consequent in the clock cycle after it.
`define IRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IRL_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define IRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ src/irl_pkg.sv @@
// Types, widths and codes shared by the range lookup modules.
package irl_pkg;

  localparam int DEF_RECORD_DEPTH = 131072;
  localparam int PREFIX_ENTRIES   = 65536;

  localparam int FUNC_W     = 2;
  localparam int IP_W       = 32;
  localparam int PFX_SLOT_W = $clog2(PREFIX_ENTRIES);
  localparam int REC_FLD_W  = 17;
  localparam int CNT_W      = 18;
  localparam int OFF_W      = 24;
  localparam int LEN_W      = 16;

  // Function codes of an input transfer; code 3 does nothing.
  localparam logic [FUNC_W-1:0] FUNC_PFX_WR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REC_WR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PFX,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Prefix memory access: single port, read or write.
  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic [PFX_SLOT_W-1:0] addr;
    logic [REC_FLD_W-1:0]  wr_data;
  } pfx_req_t;

  // Record memory enables; the address width follows the depth.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } rec_ctl_t;

  typedef struct packed {
    logic [IP_W-1:0]  end_ip;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } rec_data_t;

endpackage

@@ src/ip_range_lookup_top.sv @@
// Table writes are performed at the input transfer; a lookup reads the prefix table, then
// scans records from the prefix start, one record per cycle on the record memory's single
// read port. One item at a time: a lookup holds off the input until its result is loaded
// into the result register, which waits for any result stall.
// Reset: synchronous, clears the sequencer, result valid and record count; table
// contents are undefined until written and get no clearing pass.
module ip_range_lookup_top
  import irl_pkg::*;
#(
  parameter int RECORD_DEPTH = DEF_RECORD_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     func,
  input  logic [IP_W-1:0]       ip_address,
  input  logic [PFX_SLOT_W-1:0] prefix_slot,
  input  logic [REC_FLD_W-1:0]  prefix_start,
  input  logic [REC_FLD_W-1:0]  record_slot,
  input  logic [IP_W-1:0]       record_end_ip,
  input  logic [OFF_W-1:0]      record_offset,
  input  logic [LEN_W-1:0]      record_length,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [OFF_W-1:0]      data_offset,
  output logic [LEN_W-1:0]      data_length
);

  localparam int RAW = $clog2(RECORD_DEPTH);

  pfx_req_t             pfx_req;
  logic [REC_FLD_W-1:0] pfx_rd_data;
  rec_ctl_t             rec_ctl;
  logic [RAW-1:0]       rec_addr;
  rec_data_t            rec_wr_data;
  rec_data_t            rec_rd_data;

  // Sequencer and result register.
  irl_lookup_fsm #(
    .RECORD_DEPTH(RECORD_DEPTH)
  ) u_fsm (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .ip_address   (ip_address),
    .prefix_slot  (prefix_slot),
    .prefix_start (prefix_start),
    .record_slot  (record_slot),
    .record_end_ip(record_end_ip),
    .record_offset(record_offset),
    .record_length(record_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .data_offset  (data_offset),
    .data_length  (data_length),
    .pfx_req      (pfx_req),
    .pfx_rd_data  (pfx_rd_data),
    .rec_ctl      (rec_ctl),
    .rec_addr     (rec_addr),
    .rec_wr_data  (rec_wr_data),
    .rec_rd_data  (rec_rd_data)
  );

  // Prefix table.
  irl_prefix_ram u_pfx_ram (
    .clk    (clk),
    .req    (pfx_req),
    .rd_data(pfx_rd_data)
  );

  // Record table.
  irl_record_ram #(
    .RECORD_DEPTH(RECORD_DEPTH)
  ) u_rec_ram (
    .clk    (clk),
    .ctl    (rec_ctl),
    .addr   (rec_addr),
    .wr_data(rec_wr_data),
    .rd_data(rec_rd_data)
  );

endmodule

@@ src/irl_prefix_ram.sv @@
// Prefix table memory: first record index for each top-16-bit prefix.
module irl_prefix_ram
  import irl_pkg::*;
(
  input  logic                 clk,
  input  pfx_req_t             req,
  output logic [REC_FLD_W-1:0] rd_data
);

  logic [REC_FLD_W-1:0] mem [PREFIX_ENTRIES];

  // Write or read one entry; read data is registered.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

@@ src/irl_record_ram.sv @@
// Record table memory: range end address, data offset and length per record.
module irl_record_ram
  import irl_pkg::*;
#(
  parameter int RECORD_DEPTH = DEF_RECORD_DEPTH
) (
  input  logic                            clk,
  input  rec_ctl_t                        ctl,
  input  logic [$clog2(RECORD_DEPTH)-1:0] addr,
  input  rec_data_t                       wr_data,
  output rec_data_t                       rd_data
);

  rec_data_t mem [RECORD_DEPTH];

  // Write or read one record; read data is registered.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

@@ src/irl_lookup_fsm.sv @@
// Lookup sequencer: decodes transfers, drives the tables and scans records.
`include "ip_range_lookup_top_defines.svh"

module irl_lookup_fsm
  import irl_pkg::*;
#(
  parameter int RECORD_DEPTH = DEF_RECORD_DEPTH,
  localparam int RAW = $clog2(RECORD_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     func,
  input  logic [IP_W-1:0]       ip_address,
  input  logic [PFX_SLOT_W-1:0] prefix_slot,
  input  logic [REC_FLD_W-1:0]  prefix_start,
  input  logic [REC_FLD_W-1:0]  record_slot,
  input  logic [IP_W-1:0]       record_end_ip,
  input  logic [OFF_W-1:0]      record_offset,
  input  logic [LEN_W-1:0]      record_length,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [OFF_W-1:0]      data_offset,
  output logic [LEN_W-1:0]      data_length,
  // memories
  output pfx_req_t              pfx_req,
  input  logic [REC_FLD_W-1:0]  pfx_rd_data,
  output rec_ctl_t              rec_ctl,
  output logic [RAW-1:0]        rec_addr,
  output rec_data_t             rec_wr_data,
  input  rec_data_t             rec_rd_data
);

  state_t           state, state_next;
  logic [CNT_W-1:0] record_count;
  logic [IP_W-1:0]  ip;
  logic [CNT_W-1:0] limit, limit_next;
  logic [CNT_W-1:0] cur_idx, cur_idx_next;
  logic             res_found, res_found_next;
  logic [OFF_W-1:0] res_off, res_off_next;
  logic [LEN_W-1:0] res_len, res_len_next;

  logic             in_xfer;
  logic             lookup_xfer;
  logic             slot_ok;
  logic [CNT_W-1:0] start_idx;
  logic [CNT_W-1:0] idx_inc;
  logic             start_out;
  logic             hit;
  logic             inc_out;
  logic             out_free;
  logic             out_load;

  assign in_xfer     = in_valid && in_ready;
  assign lookup_xfer = in_xfer && (func == FUNC_LOOKUP);
  assign slot_ok     = (32'(record_slot) < 32'(RECORD_DEPTH));
  assign start_idx   = CNT_W'(pfx_rd_data);
  assign idx_inc     = cur_idx + CNT_W'(1);
  assign start_out   = (start_idx >= limit);
  assign hit         = (rec_rd_data.end_ip >= ip);
  assign inc_out     = (idx_inc >= limit);
  assign out_free    = !out_valid || out_ready;
  assign cfg_ready   = 1'b1;

  // Clip the record count to the table depth.
  always_comb begin
    if (32'(record_count) > 32'(RECORD_DEPTH)) begin
      limit_next = CNT_W'(RECORD_DEPTH);
    end else begin
      limit_next = record_count;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (lookup_xfer) state_next = ST_PFX;
      end
      ST_PFX: begin
        state_next = start_out ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || inc_out) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory requests, scan index and result.
  always_comb begin
    in_ready       = 1'b0;
    pfx_req        = '0;
    rec_ctl        = '0;
    rec_addr       = RAW'(record_slot);
    rec_wr_data    = '{end_ip: record_end_ip, offset: record_offset, length: record_length};
    cur_idx_next   = cur_idx;
    res_found_next = res_found;
    res_off_next   = res_off;
    res_len_next   = res_len;
    out_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready        = 1'b1;
        pfx_req.wr_data = prefix_start;
        if (in_xfer && func == FUNC_PFX_WR) begin
          pfx_req.wr_en = 1'b1;
          pfx_req.addr  = prefix_slot;
        end
        if (lookup_xfer) begin
          pfx_req.rd_en = 1'b1;
          pfx_req.addr  = ip_address[IP_W-1 -: PFX_SLOT_W];
        end
        rec_ctl.wr_en = in_xfer && (func == FUNC_REC_WR) && slot_ok;
      end
      ST_PFX: begin
        rec_addr     = RAW'(start_idx);
        cur_idx_next = start_idx;
        if (start_out) begin
          res_found_next = 1'b0;
          res_off_next   = '0;
          res_len_next   = '0;
        end else begin
          rec_ctl.rd_en = 1'b1;
        end
      end
      ST_SCAN: begin
        rec_addr = RAW'(idx_inc);
        if (hit) begin
          res_found_next = 1'b1;
          res_off_next   = rec_rd_data.offset;
          res_len_next   = rec_rd_data.length;
        end else if (inc_out) begin
          res_found_next = 1'b0;
          res_off_next   = '0;
          res_len_next   = '0;
        end else begin
          rec_ctl.rd_en = 1'b1;
          cur_idx_next  = idx_inc;
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      record_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        record_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Lookup context, scan index and result registers.
  always_ff @(posedge clk) begin
    if (lookup_xfer) begin
      ip    <= ip_address;
      limit <= limit_next;
    end
    cur_idx   <= cur_idx_next;
    res_found <= res_found_next;
    res_off   <= res_off_next;
    res_len   <= res_len_next;
    if (out_load) begin
      found       <= res_found;
      data_offset <= res_off;
      data_length <= res_len;
    end
  end

  `IRL_ASSERT_IMPL(a_scan_in_range, clk, rst, state == ST_SCAN, cur_idx < limit,
                   "scan index at or beyond the record limit")
  `IRL_ASSERT_IMPL(a_read_in_range, clk, rst, rec_ctl.rd_en, 32'(rec_addr) < 32'(RECORD_DEPTH),
                   "record read beyond the table depth")
  `IRL_ASSERT_NEXT(a_lookup_reads_prefix, clk, rst, lookup_xfer, state == ST_PFX,
                   "lookup transfer did not start a prefix read")
  `IRL_ASSERT_NEXT(a_done_delivers, clk, rst, out_load, out_valid && state == ST_IDLE,
                   "finished lookup not presented on the result channel")
  `IRL_ASSERT_IMPL(a_miss_is_zero, clk, rst, out_valid && !found,
                   data_offset == '0 && data_length == '0,
                   "miss result carries nonzero offset or length")

endmodule
